@@ hw/rtl/selective_repeat_receiver_reorder_unit_macros.svh @@
// assertion macros shared by the reorder unit checker
// no dependencies; every macro takes the clock and active-low reset by name
`ifndef SELECTIVE_REPEAT_RECEIVER_REORDER_UNIT_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVER_REORDER_UNIT_MACROS_SVH

// same-cycle implication
`define SRR_ASSERT_SAME(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SRR_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/srr_pkg.sv @@
// shared types and constants of the selective-repeat reorder unit
// no dependencies
package srr_pkg;

	localparam int unsigned SEQ_W = 32;
	localparam int unsigned PAYLOAD_BYTES = 20;
	localparam int unsigned SLOT_DATA_W = PAYLOAD_BYTES * 8;

	localparam logic KIND_ACK = 1'b0;
	localparam logic KIND_DELIVER = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_STORE,
		ST_READ,
		ST_EMIT
	} srr_state_t;

	typedef struct packed {
		logic capture;
		logic check;
		logic store;
		logic emit;
	} srr_cmd_t;

	typedef struct packed {
		logic good;
		logic drain;
		logic more;
		logic out_free;
	} srr_sts_t;

endpackage

@@ hw/rtl/srr_ctrl.sv @@
// controller of the reorder unit: sequences check, store and drain
// depends on srr_pkg
module srr_ctrl
	import srr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  srr_sts_t sts,
	output srr_cmd_t cmd
);

	srr_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d = sts.good ? ST_STORE : ST_IDLE;
			end
			ST_STORE: begin
				if (sts.out_free) begin
					cmd.store = 1'b1;
					state_d = sts.drain ? ST_READ : ST_IDLE;
				end
			end
			ST_READ: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = sts.more ? ST_READ : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/srr_dp.sv @@
// datapath of the reorder unit: checksum, window, slot store and output register
// depends on srr_pkg; driven by srr_ctrl through srr_cmd_t
module srr_dp
	import srr_pkg::*;
#(
	parameter int unsigned WINDOW_DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  srr_cmd_t            cmd,
	output srr_sts_t            sts,
	input  logic [31:0]         seq_num,
	input  logic signed [31:0]  ack_num,
	input  logic signed [31:0]  pkt_checksum,
	input  logic [63:0]         payload_word0,
	input  logic [63:0]         payload_word1,
	input  logic [31:0]         payload_word2,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                kind,
	output logic [31:0]         out_seq,
	output logic signed [31:0]  ack_checksum,
	output logic [63:0]         out_word0,
	output logic [63:0]         out_word1,
	output logic [31:0]         out_word2,
	output logic                last
);

	localparam int unsigned SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int unsigned SUM_W = SLOT_W + 2;
	localparam int unsigned WRAP_MOD = int'((64'd1 << 32) % 64'(WINDOW_DEPTH));
	localparam int unsigned WRAP_ADJ = (WINDOW_DEPTH - WRAP_MOD) % WINDOW_DEPTH;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

	// captured request
	logic [31:0] seq_q, ack_q, chk_q;
	logic [63:0] w0_q, w1_q;
	logic [31:0] w2_q;
	logic signed [10:0] psum0_q, psum1_q;
	logic signed [9:0]  psum2_q;
	logic signed [10:0] psum0_c, psum1_c;
	logic signed [9:0]  psum2_c;

	// window position
	logic [31:0] base_q;
	logic [SLOT_W-1:0] base_slot_q;
	logic [SLOT_W-1:0] dlow_q;
	logic wrap_q, in_win_q;
	logic [WINDOW_DEPTH-1:0] filled_q;

	// slot store
	logic [SLOT_DATA_W-1:0] slot_mem_q [WINDOW_DEPTH];
	logic [SLOT_DATA_W-1:0] rd_q;

	// output register
	logic out_valid_q, kind_q, last_q;
	logic [31:0] out_seq_q, ack_chk_q;
	logic [63:0] ow0_q, ow1_q;
	logic [31:0] ow2_q;

	logic signed [12:0] bsum_c;
	logic [31:0] sum_c, dist_c;
	logic in_win_c, wrap_c, good_c;
	logic [SUM_W-1:0] slot_sum_c;
	logic [SLOT_W-1:0] store_slot_c, next_slot_c;
	logic drain_c, more_c, out_free_c;

	always_comb begin
		psum0_c = '0;
		psum1_c = '0;
		psum2_c = '0;
		for (int i = 0; i < 8; i++) begin
			psum0_c = psum0_c + 11'(signed'(payload_word0[8*i +: 8]));
			psum1_c = psum1_c + 11'(signed'(payload_word1[8*i +: 8]));
		end
		for (int i = 0; i < 4; i++) begin
			psum2_c = psum2_c + 10'(signed'(payload_word2[8*i +: 8]));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			seq_q <= seq_num;
			ack_q <= ack_num;
			chk_q <= pkt_checksum;
			w0_q <= payload_word0;
			w1_q <= payload_word1;
			w2_q <= payload_word2;
			psum0_q <= psum0_c;
			psum1_q <= psum1_c;
			psum2_q <= psum2_c;
		end
	end

	// checksum and window test
	always_comb begin
		bsum_c = 13'(psum0_q) + 13'(psum1_q) + 13'(psum2_q);
		sum_c = ack_q + seq_q + 32'(bsum_c);
		good_c = (sum_c == chk_q);
		dist_c = seq_q - base_q;
		in_win_c = (dist_c < 32'(WINDOW_DEPTH));
		wrap_c = (seq_q < base_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			dlow_q <= dist_c[SLOT_W-1:0];
			wrap_q <= wrap_c;
			in_win_q <= in_win_c;
		end
	end

	// slot of the stored packet, corrected when the window crosses the sequence wrap
	always_comb begin
		slot_sum_c = SUM_W'(base_slot_q) + SUM_W'(dlow_q)
			+ (wrap_q ? SUM_W'(WRAP_ADJ) : SUM_W'(0));
		if (slot_sum_c >= SUM_W'(2 * WINDOW_DEPTH)) begin
			store_slot_c = SLOT_W'(slot_sum_c - SUM_W'(2 * WINDOW_DEPTH));
		end else if (slot_sum_c >= SUM_W'(WINDOW_DEPTH)) begin
			store_slot_c = SLOT_W'(slot_sum_c - SUM_W'(WINDOW_DEPTH));
		end else begin
			store_slot_c = SLOT_W'(slot_sum_c);
		end
		drain_c = filled_q[base_slot_q] | (in_win_q & (store_slot_c == base_slot_q));
		if (base_q == '1 || base_slot_q == LAST_SLOT) begin
			next_slot_c = '0;
		end else begin
			next_slot_c = base_slot_q + SLOT_W'(1);
		end
		more_c = filled_q[next_slot_c] & (next_slot_c != base_slot_q);
		out_free_c = !out_valid_q | out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			base_slot_q <= '0;
			filled_q <= '0;
		end else if (cmd.store) begin
			if (in_win_q) begin
				filled_q[store_slot_c] <= 1'b1;
			end
		end else if (cmd.emit) begin
			filled_q[base_slot_q] <= 1'b0;
			base_q <= base_q + 32'd1;
			base_slot_q <= next_slot_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store && in_win_q) begin
			slot_mem_q[store_slot_c] <= {w2_q, w1_q, w0_q};
		end
		rd_q <= slot_mem_q[base_slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.store || cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			kind_q <= KIND_ACK;
			out_seq_q <= seq_q;
			ack_chk_q <= {seq_q[30:0], 1'b0};
			ow0_q <= '0;
			ow1_q <= '0;
			ow2_q <= '0;
			last_q <= !drain_c;
		end else if (cmd.emit) begin
			kind_q <= KIND_DELIVER;
			out_seq_q <= base_q;
			ack_chk_q <= '0;
			ow0_q <= rd_q[63:0];
			ow1_q <= rd_q[127:64];
			ow2_q <= rd_q[159:128];
			last_q <= !more_c;
		end
	end

	assign sts.good = good_c;
	assign sts.drain = drain_c;
	assign sts.more = more_c;
	assign sts.out_free = out_free_c;

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign out_seq = out_seq_q;
	assign ack_checksum = ack_chk_q;
	assign out_word0 = ow0_q;
	assign out_word1 = ow1_q;
	assign out_word2 = ow2_q;
	assign last = last_q;

endmodule

@@ hw/rtl/selective_repeat_receiver_reorder_unit.sv @@
// top level of the selective-repeat receiver reorder unit
// depends on srr_pkg, srr_ctrl and srr_dp
//
// Input channel (in_valid/in_ready) takes one packet request: sequence number,
// ack number, header checksum and a 20-byte payload in three words.
// Output channel (out_valid/out_ready) gives results: a packet with a bad
// checksum gives none; a good one gives an ack (kind 0), then every payload now
// in order from the expected base (kind 1); last marks the final result.
// Timing: the packet is checked the cycle after acceptance; the ack then enters
// the output register in the store step, once the register is free.
// Each delivered payload takes a slot memory read, then a load of the output
// register. in_ready is high only between packets.
// Reset empties every slot, sets the expected base to zero and empties the
// output register; no clearing pass is needed.
// When the receiver stalls, the finished result waits in the output register
// and the unit holds at its next ack or delivery until the register frees.
module selective_repeat_receiver_reorder_unit
	import srr_pkg::*;
#(
	parameter int unsigned WINDOW_DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [31:0]         seq_num,
	input  logic signed [31:0]  ack_num,
	input  logic signed [31:0]  pkt_checksum,
	input  logic [63:0]         payload_word0,
	input  logic [63:0]         payload_word1,
	input  logic [31:0]         payload_word2,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                kind,
	output logic [31:0]         out_seq,
	output logic signed [31:0]  ack_checksum,
	output logic [63:0]         out_word0,
	output logic [63:0]         out_word1,
	output logic [31:0]         out_word2,
	output logic                last
);

	srr_cmd_t cmd;
	srr_sts_t sts;

	srr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	srr_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.seq_num       (seq_num),
		.ack_num       (ack_num),
		.pkt_checksum  (pkt_checksum),
		.payload_word0 (payload_word0),
		.payload_word1 (payload_word1),
		.payload_word2 (payload_word2),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.out_seq       (out_seq),
		.ack_checksum  (ack_checksum),
		.out_word0     (out_word0),
		.out_word1     (out_word1),
		.out_word2     (out_word2),
		.last          (last)
	);

endmodule

@@ hw/rtl/srr_checker.sv @@
// port-level checker of the reorder unit, bound to the top level
// depends on srr_pkg and selective_repeat_receiver_reorder_unit_macros.svh
`include "selective_repeat_receiver_reorder_unit_macros.svh"

module srr_checker
	import srr_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               kind,
	input logic [31:0]        out_seq,
	input logic signed [31:0] ack_checksum,
	input logic [63:0]        out_word0,
	input logic [63:0]        out_word1,
	input logic [31:0]        out_word2
);

	`SRR_ASSERT_SAME(a_ack_checksum, clk, arst_n, out_valid && kind == KIND_ACK, ack_checksum == {out_seq[30:0], 1'b0}, "ack checksum is not twice the sequence number")
	`SRR_ASSERT_SAME(a_ack_no_payload, clk, arst_n, out_valid && kind == KIND_ACK, out_word0 == '0 && out_word1 == '0 && out_word2 == '0, "ack carries payload")
	`SRR_ASSERT_SAME(a_deliver_no_checksum, clk, arst_n, out_valid && kind == KIND_DELIVER, ack_checksum == '0, "delivery carries a checksum")
	`SRR_ASSERT_NEXT(a_one_request_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready, "request taken while one is in work")
	`SRR_ASSERT_NEXT(a_stalled_result_holds, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_seq) && $stable(kind), "stalled result changed")

endmodule

bind selective_repeat_receiver_reorder_unit srr_checker u_srr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.kind         (kind),
	.out_seq      (out_seq),
	.ack_checksum (ack_checksum),
	.out_word0    (out_word0),
	.out_word1    (out_word1),
	.out_word2    (out_word2)
);

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// testbench of the selective-repeat receiver reorder unit: directed then random packet
// requests, with acks and in-order deliveries predicted by a scoreboard class
// depends on srr_pkg and selective_repeat_receiver_reorder_unit
module testbench;
	import srr_pkg::*;

	localparam int unsigned WINDOW = 32;
	localparam int unsigned RANDOM_REQUESTS = 100;
	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int unsigned SETTLE_CYCLES = 20;
	localparam int unsigned LONG_HOLD = 300;

	typedef struct {
		logic        kind;
		logic [31:0] seq;
		logic [31:0] ck;
		logic [63:0] w0;
		logic [63:0] w1;
		logic [31:0] w2;
		logic        last;
	} rx_result_t;

	class reorder_scoreboard;
		logic [31:0] next_deliver = '0;
		bit          slot_full[WINDOW];
		logic [63:0] slot_w0[WINDOW];
		logic [63:0] slot_w1[WINDOW];
		logic [31:0] slot_w2[WINDOW];
		rx_result_t  awaited_results[$];
		int unsigned errors = 0;

		function logic [31:0] header_sum(logic [31:0] seq, logic [31:0] ack, logic [63:0] w0,
				logic [63:0] w1, logic [31:0] w2);
			logic [159:0] bytes;
			logic [31:0]  total;
			bytes = {w2, w1, w0};
			total = ack + seq;
			for (int i = 0; i < PAYLOAD_BYTES; i++)
				total += {{24{bytes[8*i+7]}}, bytes[8*i +: 8]};
			return total;
		endfunction

		function void predict_packet(logic [31:0] seq, logic [31:0] ack, logic [31:0] chk,
				logic [63:0] w0, logic [63:0] w1, logic [31:0] w2);
			rx_result_t  res;
			int unsigned s;
			logic [31:0] win_off;
			if (header_sum(seq, ack, w0, w1, w2) != chk)
				return;
			res.kind = KIND_ACK;
			res.seq = seq;
			res.ck = seq + seq;
			res.w0 = '0;
			res.w1 = '0;
			res.w2 = '0;
			res.last = 1'b0;
			win_off = seq - next_deliver;
			if (win_off < WINDOW) begin
				s = seq % WINDOW;
				slot_full[s] = 1'b1;
				slot_w0[s] = w0;
				slot_w1[s] = w1;
				slot_w2[s] = w2;
			end
			s = next_deliver % WINDOW;
			while (slot_full[s]) begin
				awaited_results.insert(awaited_results.size(), res);
				res.kind = KIND_DELIVER;
				res.seq = next_deliver;
				res.ck = '0;
				res.w0 = slot_w0[s];
				res.w1 = slot_w1[s];
				res.w2 = slot_w2[s];
				slot_full[s] = 1'b0;
				next_deliver++;
				s = next_deliver % WINDOW;
			end
			res.last = 1'b1;
			awaited_results.insert(awaited_results.size(), res);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(rx_result_t got);
			rx_result_t want;
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result kind %0d seq %h", $time, got.kind, got.seq);
				errors++;
				return;
			end
			want = awaited_results.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("out_seq", want.seq, got.seq);
			compare_field("ack_checksum", want.ck, got.ck);
			compare_field("out_word0", want.w0, got.w0);
			compare_field("out_word1", want.w1, got.w1);
			compare_field("out_word2", want.w2, got.w2);
			compare_field("last", want.last, got.last);
		endfunction

		function int unsigned pending();
			return awaited_results.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [31:0]        seq_num;
	logic signed [31:0] ack_num;
	logic signed [31:0] pkt_checksum;
	logic [63:0]        payload_word0;
	logic [63:0]        payload_word1;
	logic [31:0]        payload_word2;
	logic               out_valid;
	logic               out_ready;
	logic               kind;
	logic [31:0]        out_seq;
	logic signed [31:0] ack_checksum;
	logic [63:0]        out_word0;
	logic [63:0]        out_word1;
	logic [31:0]        out_word2;
	logic               last;

	reorder_scoreboard sb = new;
	logic [31:0]       next_base;
	bit                calm_tx;
	bit                hold_go;
	bit                settling;
	int unsigned       cycle_count;

	selective_repeat_receiver_reorder_unit #(
		.WINDOW_DEPTH(WINDOW)
	) dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int unsigned next_gap();
		int unsigned r;
		if (calm_tx)
			return 0;
		r = $urandom_range(0, 19);
		if (r < 10)
			return 0;
		if (r < 17)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	task automatic send_packet(input logic [31:0] seq, input logic [31:0] ack,
			input logic [31:0] chk, input logic [63:0] w0, input logic [63:0] w1,
			input logic [31:0] w2);
		int unsigned gap;
		in_valid <= 1'b1;
		seq_num <= seq;
		ack_num <= ack;
		pkt_checksum <= chk;
		payload_word0 <= w0;
		payload_word1 <= w1;
		payload_word2 <= w2;
		do @(posedge clk); while (!in_ready);
		sb.predict_packet(seq, ack, chk, w0, w1, w2);
		gap = next_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_good(input logic [31:0] seq, input logic [31:0] ack,
			input logic [63:0] w0, input logic [63:0] w1, input logic [31:0] w2);
		send_packet(seq, ack, sb.header_sum(seq, ack, w0, w1, w2), w0, w1, w2);
	endtask

	task automatic send_corrupt(input logic [31:0] seq, input logic [63:0] w0,
			input logic [63:0] w1, input logic [31:0] w2);
		logic [31:0] ack;
		ack = $urandom;
		send_packet(seq, ack, sb.header_sum(seq, ack, w0, w1, w2) ^ (32'h1 << $urandom_range(0, 31)),
			w0, w1, w2);
	endtask

	task automatic send_noise(input logic [31:0] seq);
		logic [31:0] far;
		case ($urandom_range(0, 3))
			0: send_corrupt(seq, rand64(), rand64(), $urandom);
			1: send_good(next_base + WINDOW + $urandom_range(0, 1000), $urandom, rand64(),
				rand64(), $urandom);
			2: begin
				far = $urandom;
				if (far - next_base < WINDOW)
					far = far + WINDOW;
				send_good(far, $urandom, rand64(), rand64(), $urandom);
			end
			default: send_good(seq, $urandom, rand64(), rand64(), $urandom);
		endcase
	endtask

	task automatic directed_part();
		logic [63:0] w0;
		logic [63:0] w1;
		logic [31:0] w2;
		send_good(32'd0, 32'd0, 64'd0, 64'd0, 32'd0);
		send_good(32'd1, 32'h8000_0000, '1, '1, '1);
		// already delivered, so behind the window
		send_good(32'd0, 32'h7fff_ffff, {8{8'h80}}, {8{8'h80}}, {4{8'h80}});
		send_corrupt(32'd2, rand64(), rand64(), $urandom);
		// last slot of the window, then just past it
		send_good(32'd33, $urandom, rand64(), rand64(), $urandom);
		send_good(32'd34, $urandom, rand64(), rand64(), $urandom);
		// duplicate overwrites, then the gap fills and three drain
		send_good(32'd4, $urandom, rand64(), rand64(), $urandom);
		send_good(32'd4, $urandom, {8{8'h7f}}, {8{8'h7f}}, {4{8'h7f}});
		send_good(32'd3, $urandom, rand64(), rand64(), $urandom);
		send_good(32'd2, $urandom, rand64(), rand64(), $urandom);
		w0 = rand64();
		w1 = rand64();
		w2 = $urandom;
		send_good(32'd5, 32'h7fff_ffff - sb.header_sum(32'd5, 32'd0, w0, w1, w2), w0, w1, w2);
		w0 = rand64();
		w1 = rand64();
		w2 = $urandom;
		send_good(32'd6, 32'h8000_0000 - sb.header_sum(32'd6, 32'd0, w0, w1, w2), w0, w1, w2);
		send_good(32'hffff_ffff, 32'h7fff_ffff, rand64(), rand64(), $urandom);
		send_corrupt(32'd7, '1, '1, '1);
		send_good(32'h8000_0000, $urandom, rand64(), rand64(), $urandom);
		send_corrupt(32'hffff_ffff, 64'd0, 64'd0, 32'd0);
		next_base = 32'd7;
	endtask

	task automatic random_part();
		logic [31:0] order[$];
		logic [31:0] tmp;
		int unsigned sent;
		int unsigned span;
		int unsigned pick;
		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			calm_tx = ($urandom_range(0, 3) == 0);
			order.delete();
			if (sent == 0) begin
				// full window in reverse while the receiver holds off: the base comes last
				span = WINDOW;
				calm_tx = 1'b1;
				hold_go = 1'b1;
				for (int i = int'(span) - 1; i >= 0; i--)
					order.insert(order.size(), next_base + i);
			end else begin
				span = ($urandom_range(0, 9) == 0) ? WINDOW : $urandom_range(1, 6);
				for (int i = 0; i < span; i++)
					order.insert(order.size(), next_base + i);
				for (int i = int'(span) - 1; i > 0; i--) begin
					pick = $urandom_range(0, i);
					tmp = order[i];
					order[i] = order[pick];
					order[pick] = tmp;
				end
			end
			foreach (order[i]) begin
				if ($urandom_range(0, 5) == 0) begin
					send_noise(order[i]);
					sent++;
				end
				send_good(order[i], $urandom, rand64(), rand64(), $urandom);
				sent++;
			end
			next_base += span;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		seq_num <= '0;
		ack_num <= '0;
		pkt_checksum <= '0;
		payload_word0 <= '0;
		payload_word1 <= '0;
		payload_word2 <= '0;
		calm_tx = 1'b0;
		hold_go = 1'b0;
		settling = 1'b0;
		next_base = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_part();
		random_part();
		in_valid <= 1'b0;
		settling = 1'b1;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

	// receiving side
	initial begin
		int unsigned stall_left;
		int unsigned phase_left;
		int unsigned r;
		bit          calm_rx;
		bit          hold_done;
		rx_result_t  got;
		stall_left = 0;
		phase_left = 0;
		calm_rx = 1'b0;
		hold_done = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.kind = kind;
				got.seq = out_seq;
				got.ck = ack_checksum;
				got.w0 = out_word0;
				got.w1 = out_word1;
				got.w2 = out_word2;
				got.last = last;
				sb.check_result(got);
			end
			if (phase_left == 0) begin
				calm_rx = ($urandom_range(0, 2) == 0);
				phase_left = $urandom_range(40, 200);
			end else begin
				phase_left--;
			end
			if (hold_go && !hold_done) begin
				stall_left = LONG_HOLD;
				hold_done = 1'b1;
			end else if (settling) begin
				stall_left = 0;
			end else if (stall_left == 0 && !calm_rx) begin
				r = $urandom_range(0, 19);
				if (r >= 12 && r < 18)
					stall_left = $urandom_range(1, 3);
				else if (r == 18)
					stall_left = $urandom_range(8, 20);
				else if (r == 19)
					stall_left = $urandom_range(30, 60);
			end
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench: done, errors");
		$finish;
	end

endmodule

@@ selective_repeat_receiver_reorder_unit.f @@
+incdir+hw/rtl
hw/rtl/srr_pkg.sv
hw/rtl/srr_ctrl.sv
hw/rtl/srr_dp.sv
hw/rtl/selective_repeat_receiver_reorder_unit.sv
hw/rtl/srr_checker.sv
verif/testbench.sv
